// ===== rtl/tlbp_pkg.sv =====
package tlbp_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTOMATON_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_MODE   = 1'd1;

    typedef logic [2:0] t_kind;

    // Automaton kinds
    localparam t_kind KIND_LAST = 3'd0;
    localparam t_kind KIND_A1   = 3'd1;
    localparam t_kind KIND_SAT  = 3'd2;
    localparam t_kind KIND_A3   = 3'd3;
    localparam t_kind KIND_A4   = 3'd4;

    // History table modes
    localparam logic MODE_ASSOC  = 1'b0;
    localparam logic MODE_DIRECT = 1'b1;

    // Commands
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Request control toward the set update logic
    typedef struct packed {
        logic touch;    // predict, or a conditional update: refresh LRU on hit
        logic update;   // conditional update: write history
        logic outcome;  // resolved direction
    } t_req_ctl;

    // Status back from the set update logic
    typedef struct packed {
        logic hit;
        logic row_we;
    } t_set_status;

    // Prediction of an automaton state
    function automatic logic pred_of(t_kind kind, logic [1:0] st);
        logic p;
        p = 1'b0;
        case (kind)
            KIND_LAST, KIND_A1: p = (st != 2'd0);
            KIND_SAT, KIND_A3, KIND_A4: p = st[1];
            default: p = 1'b0;
        endcase
        return p;
    endfunction

    // Next automaton state for a resolved outcome
    function automatic logic [1:0] next_of(t_kind kind, logic [1:0] st, logic o);
        logic [1:0] n;
        n = 2'd0;
        case (kind)
            KIND_LAST: n = {1'b0, o};
            KIND_A1:   n = {st[0], o};
            KIND_SAT: begin
                case (st)
                    2'd0: n = o ? 2'd1 : 2'd0;
                    2'd1: n = o ? 2'd2 : 2'd0;
                    2'd2: n = o ? 2'd3 : 2'd1;
                    default: n = o ? 2'd3 : 2'd2;
                endcase
            end
            KIND_A3: begin
                case (st)
                    2'd0: n = o ? 2'd1 : 2'd0;
                    2'd1: n = o ? 2'd3 : 2'd0;
                    2'd2: n = o ? 2'd0 : 2'd3;
                    default: n = o ? 2'd3 : 2'd2;
                endcase
            end
            KIND_A4: begin
                case (st)
                    2'd0: n = o ? 2'd1 : 2'd0;
                    2'd1: n = o ? 2'd3 : 2'd0;
                    2'd2: n = o ? 2'd3 : 2'd1;
                    default: n = o ? 2'd3 : 2'd2;
                endcase
            end
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/tlbp_ram.sv =====
module tlbp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tlbp_rem_unit.sv =====
module tlbp_rem_unit #(
    parameter int DIVISOR  = 3,
    parameter int VAL_BITS = 48
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [VAL_BITS-1:0]                           i_value,
    output logic                                          o_done,
    output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] o_rem
);

    localparam int REM_BITS = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam int STEPS    = (VAL_BITS + 3) / 4;
    localparam int PAD_BITS = STEPS * 4;
    localparam int CNT_W    = $clog2(STEPS + 1);
    localparam logic [REM_BITS:0] DIV_EXT  = (REM_BITS + 1)'(DIVISOR);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_INIT = CNT_W'(STEPS);

    logic [PAD_BITS-1:0] r_val;
    logic [REM_BITS-1:0] r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [REM_BITS-1:0] step_rem;
    logic [REM_BITS:0]   step_t;

    // Fold in four bits, most significant first, one compare-subtract each
    always_comb begin
        step_rem = r_rem;
        step_t   = '0;
        for (int k = 0; k < 4; k++) begin
            step_t = {step_rem, r_val[PAD_BITS-1-k]};
            if (step_t >= DIV_EXT) begin
                step_t = step_t - DIV_EXT;
            end
            step_rem = step_t[REM_BITS-1:0];
        end
    end

    // Sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_INIT;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_LAST;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shift and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= PAD_BITS'(i_value);
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << 4;
            r_rem <= step_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/tlbp_set_update.sv =====
module tlbp_set_update #(
    parameter int WAYS      = 4,
    parameter int AGE_BITS  = 2,
    parameter int TAG_BITS  = 40,
    parameter int HIST_BITS = 12
) (
    input  logic [WAYS*(1+AGE_BITS+TAG_BITS+HIST_BITS)-1:0] i_row,
    input  logic [TAG_BITS-1:0]                             i_tag,
    input  tlbp_pkg::t_req_ctl                              i_ctl,
    output tlbp_pkg::t_set_status                           o_status,
    output logic [HIST_BITS-1:0]                            o_hist,
    output logic [WAYS*(1+AGE_BITS+TAG_BITS+HIST_BITS)-1:0] o_row
);

    localparam int WAY_W  = 1 + AGE_BITS + TAG_BITS + HIST_BITS;
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(WAYS - 1);
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

    logic [WAYS-1:0]      valid_v;
    logic [WAYS-1:0]      hit_v;
    logic [AGE_BITS-1:0]  age_v   [WAYS];
    logic [TAG_BITS-1:0]  tag_v   [WAYS];
    logic [HIST_BITS-1:0] hist_v  [WAYS];
    logic [WAYS-1:0]      new_valid;
    logic [AGE_BITS-1:0]  new_age [WAYS];
    logic [TAG_BITS-1:0]  new_tag [WAYS];
    logic [HIST_BITS-1:0] new_hist[WAYS];
    logic                 hit_any;
    logic [WAY_IW-1:0]    hit_way;
    logic                 free_any;
    logic [WAY_IW-1:0]    free_way;
    logic [WAY_IW-1:0]    lru_way;
    logic [WAY_IW-1:0]    slot;
    logic [AGE_BITS-1:0]  old_age;
    logic [HIST_BITS-1:0] hist;
    logic [HIST_BITS-1:0] nh;

    always_comb begin
        // Unpack ways: valid, age, tag, history from the top bit down
        for (int i = 0; i < WAYS; i++) begin
            hist_v[i]  = i_row[i*WAY_W +: HIST_BITS];
            tag_v[i]   = i_row[i*WAY_W + HIST_BITS +: TAG_BITS];
            age_v[i]   = i_row[i*WAY_W + HIST_BITS + TAG_BITS +: AGE_BITS];
            valid_v[i] = i_row[i*WAY_W + WAY_W - 1];
            hit_v[i]   = valid_v[i] && (tag_v[i] == i_tag);
        end

        // Find the hit way, the first free way and the oldest way
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        lru_way  = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!hit_any && hit_v[i]) begin
                hit_any = 1'b1;
                hit_way = WAY_IW'(i);
            end
            if (!free_any && !valid_v[i]) begin
                free_any = 1'b1;
                free_way = WAY_IW'(i);
            end
            if (age_v[i] == AGE_MAX) begin
                lru_way = WAY_IW'(i);
            end
        end

        old_age = age_v[hit_way];
        hist    = hit_any ? hist_v[hit_way] : '0;
        nh      = HIST_BITS'({hist, i_ctl.outcome});
        slot    = free_any ? free_way : lru_way;

        for (int i = 0; i < WAYS; i++) begin
            new_valid[i] = valid_v[i];
            new_age[i]   = age_v[i];
            new_tag[i]   = tag_v[i];
            new_hist[i]  = hist_v[i];
        end

        if (hit_any) begin
            // Move the hit way to most recent
            for (int i = 0; i < WAYS; i++) begin
                if (valid_v[i] && (age_v[i] < old_age)) begin
                    new_age[i] = age_v[i] + AGE_ONE;
                end
            end
            new_age[hit_way] = '0;
            if (i_ctl.update) begin
                new_hist[hit_way] = nh;
            end
        end else begin
            // Allocate a free way or replace the oldest one
            for (int i = 0; i < WAYS; i++) begin
                if (valid_v[i] && (WAY_IW'(i) != slot)) begin
                    new_age[i] = age_v[i] + AGE_ONE;
                end
            end
            new_valid[slot] = 1'b1;
            new_age[slot]   = '0;
            new_tag[slot]   = i_tag;
            new_hist[slot]  = nh;
        end

        // Repack
        for (int i = 0; i < WAYS; i++) begin
            o_row[i*WAY_W +: WAY_W] = {new_valid[i], new_age[i], new_tag[i], new_hist[i]};
        end
    end

    assign o_hist          = hist;
    assign o_status.hit    = hit_any;
    assign o_status.row_we = hit_any ? i_ctl.touch : i_ctl.update;

endmodule

// ===== rtl/two_level_adaptive_branch_predictor.sv =====
// Per-address two-level branch predictor. Each input word is a predict or an
// update request for one branch address; each gives one result word with the
// prediction taken from the pattern state before any update, and the history
// table hit flag. Items are handled one at a time: with power-of-two set and
// entry counts an item goes through the history table read, the pattern table
// read, and the pattern write with result load, which waits while an earlier
// result is still held on the output. With other counts a remainder unit
// folding four address bits a cycle and an index load come before the
// history table read. The next word is accepted while a finished result
// still waits on the output register. After reset a clearing pass over
// max(2^HIST_BITS, HRT_ENTRIES) table entries (4096 at the defaults) runs
// before the first word is accepted; configuration writes are taken at any
// time, but should be issued only while no request is in flight.
module two_level_adaptive_branch_predictor #(
    parameter int HIST_BITS   = 12,
    parameter int HRT_ENTRIES = 1024,
    parameter int WAYS        = 4,
    parameter int ADDR_BITS   = 48
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Request stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata from bit 0: branch_address, outcome, is_conditional, zero pad
    input  logic [((ADDR_BITS + 9) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: command
    input  logic                                   i_s_tuser,
    // Result stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata from bit 0: prediction, history_hit, zero pad
    output logic [7:0]                             o_m_tdata,
    // Configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tlbp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tlbp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SETS       = ((HRT_ENTRIES / WAYS) > 0) ? (HRT_ENTRIES / WAYS) : 1;
    localparam int SET_BITS   = $clog2(SETS + 1) - 1;
    localparam int TAG_BITS   = ADDR_BITS - SET_BITS;
    localparam int AGE_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W      = 1 + AGE_BITS + TAG_BITS + HIST_BITS;
    localparam int ROW_W      = WAYS * WAY_W;
    localparam int SET_AW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int DIR_AW     = $clog2(HRT_ENTRIES);
    localparam int PT_ENTRIES = 1 << HIST_BITS;
    localparam int CLR_DEPTH  = (PT_ENTRIES > HRT_ENTRIES) ? PT_ENTRIES : HRT_ENTRIES;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam bit POW2       = ((SETS & (SETS - 1)) == 0)
                             && ((HRT_ENTRIES & (HRT_ENTRIES - 1)) == 0);

    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W-1:0] CLR_ONE  = CLR_W'(1);
    localparam logic [CLR_W:0]   SET_LIM  = (CLR_W + 1)'(SETS);
    localparam logic [CLR_W:0]   DIR_LIM  = (CLR_W + 1)'(HRT_ENTRIES);
    localparam logic [CLR_W:0]   PT_LIM   = (CLR_W + 1)'(PT_ENTRIES);
    localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(SETS - 1);
    localparam logic [ADDR_BITS-1:0] DIR_MASK = ADDR_BITS'(HRT_ENTRIES - 1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_IDX   = 3'd3;
    localparam logic [2:0] ST_HRT   = 3'd4;
    localparam logic [2:0] ST_PT    = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CLR_W-1:0]      r_clr_cnt, n_clr_cnt;
    logic                  r_m_valid, n_m_valid;
    tlbp_pkg::t_kind       r_kind;
    logic                  r_mode;

    logic                  r_cmd;
    logic                  r_outcome;
    logic                  r_cond;
    logic [TAG_BITS-1:0]   r_tag;
    logic [SET_AW-1:0]     r_set_idx;
    logic [DIR_AW-1:0]     r_dir_idx;
    logic [HIST_BITS-1:0]  r_pidx;
    logic                  r_hit;
    logic                  r_pred_out;
    logic                  r_hit_out;

    logic [ADDR_BITS-1:0]  in_addr;
    logic                  in_outcome;
    logic                  in_cond;
    logic [SET_AW-1:0]     in_set_idx;
    logic [DIR_AW-1:0]     in_dir_idx;
    logic                  s_accept;
    logic                  clearing;
    logic                  out_free;
    logic                  pt_go;

    logic                  set_done, dir_done;
    logic [SET_AW-1:0]     set_rem;
    logic [DIR_AW-1:0]     dir_rem;

    logic                  set_we, set_re;
    logic [SET_AW-1:0]     set_waddr, set_raddr;
    logic [ROW_W-1:0]      set_wdata, set_rdata, set_new_row;
    logic                  dir_we, dir_re;
    logic [DIR_AW-1:0]     dir_waddr, dir_raddr;
    logic [HIST_BITS-1:0]  dir_wdata, dir_rdata, dir_nh;
    logic                  pt_we, pt_re;
    logic [HIST_BITS-1:0]  pt_waddr, pt_raddr;
    logic [1:0]            pt_wdata, pt_rdata;

    tlbp_pkg::t_req_ctl    ctl;
    tlbp_pkg::t_set_status set_status;
    logic [HIST_BITS-1:0]  set_hist;
    logic [HIST_BITS-1:0]  hist_sel;
    logic                  hit_sel;

    // Request word fields and address mapping
    assign in_addr    = i_s_tdata[ADDR_BITS-1:0];
    assign in_outcome = i_s_tdata[ADDR_BITS];
    assign in_cond    = i_s_tdata[ADDR_BITS+1];
    assign in_set_idx = SET_AW'(in_addr & SET_MASK);
    assign in_dir_idx = DIR_AW'(in_addr & DIR_MASK);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign clearing    = (r_state == ST_CLEAR);
    assign out_free    = !r_m_valid || i_m_tready;
    assign pt_go       = (r_state == ST_PT) && out_free;

    assign ctl.update  = (r_cmd == tlbp_pkg::CMD_UPDATE) && r_cond;
    assign ctl.touch   = (r_cmd == tlbp_pkg::CMD_PREDICT) || ctl.update;
    assign ctl.outcome = r_outcome;

    // Remainder units for set and direct indexes at other than power-of-two sizes
    tlbp_rem_unit #(
        .DIVISOR  (SETS),
        .VAL_BITS (ADDR_BITS)
    ) u_set_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept && !POW2),
        .i_value (in_addr),
        .o_done  (set_done),
        .o_rem   (set_rem)
    );

    tlbp_rem_unit #(
        .DIVISOR  (HRT_ENTRIES),
        .VAL_BITS (ADDR_BITS)
    ) u_dir_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept && !POW2),
        .i_value (in_addr),
        .o_done  (dir_done),
        .o_rem   (dir_rem)
    );

    // Set update logic over the row read from the tagged table
    tlbp_set_update #(
        .WAYS      (WAYS),
        .AGE_BITS  (AGE_BITS),
        .TAG_BITS  (TAG_BITS),
        .HIST_BITS (HIST_BITS)
    ) u_set_update (
        .i_row    (set_rdata),
        .i_tag    (r_tag),
        .i_ctl    (ctl),
        .o_status (set_status),
        .o_hist   (set_hist),
        .o_row    (set_new_row)
    );

    assign dir_nh   = HIST_BITS'({dir_rdata, r_outcome});
    assign hist_sel = (r_mode == tlbp_pkg::MODE_DIRECT) ? dir_rdata : set_hist;
    assign hit_sel  = (r_mode == tlbp_pkg::MODE_DIRECT) ? 1'b1 : set_status.hit;

    // Tagged table port control
    assign set_re    = (s_accept && POW2) || (r_state == ST_IDX);
    assign set_raddr = (r_state == ST_IDLE) ? in_set_idx : r_set_idx;
    assign set_we    = clearing ? ({1'b0, r_clr_cnt} < SET_LIM)
                     : ((r_state == ST_HRT) && (r_mode == tlbp_pkg::MODE_ASSOC)
                        && set_status.row_we);
    assign set_waddr = clearing ? r_clr_cnt[SET_AW-1:0] : r_set_idx;
    assign set_wdata = clearing ? '0 : set_new_row;

    // Direct table port control
    assign dir_re    = set_re;
    assign dir_raddr = (r_state == ST_IDLE) ? in_dir_idx : r_dir_idx;
    assign dir_we    = clearing ? ({1'b0, r_clr_cnt} < DIR_LIM)
                     : ((r_state == ST_HRT) && (r_mode == tlbp_pkg::MODE_DIRECT)
                        && ctl.update);
    assign dir_waddr = clearing ? r_clr_cnt[DIR_AW-1:0] : r_dir_idx;
    assign dir_wdata = clearing ? '0 : dir_nh;

    // Pattern table port control
    assign pt_re    = (r_state == ST_HRT);
    assign pt_raddr = hist_sel;
    assign pt_we    = clearing ? ({1'b0, r_clr_cnt} < PT_LIM) : (pt_go && ctl.update);
    assign pt_waddr = clearing ? r_clr_cnt[HIST_BITS-1:0] : r_pidx;
    assign pt_wdata = clearing ? 2'd0 : tlbp_pkg::next_of(r_kind, pt_rdata, r_outcome);

    tlbp_ram #(
        .DEPTH (SETS),
        .WIDTH (ROW_W)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (set_waddr),
        .i_wdata (set_wdata),
        .i_re    (set_re),
        .i_raddr (set_raddr),
        .o_rdata (set_rdata)
    );

    tlbp_ram #(
        .DEPTH (HRT_ENTRIES),
        .WIDTH (HIST_BITS)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    tlbp_ram #(
        .DEPTH (PT_ENTRIES),
        .WIDTH (2)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (pt_re),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_m_valid = r_m_valid && !i_m_tready;
        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + CLR_ONE;
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = POW2 ? ST_HRT : ST_MOD;
                end
            end
            ST_MOD: begin
                if (set_done && dir_done) begin
                    n_state = ST_IDX;
                end
            end
            ST_IDX: n_state = ST_HRT;
            ST_HRT: n_state = ST_PT;
            ST_PT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_m_valid <= 1'b0;
            r_kind    <= tlbp_pkg::KIND_SAT;
            r_mode    <= tlbp_pkg::MODE_ASSOC;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tlbp_pkg::CFG_AUTOMATON_KIND: r_kind <= i_cfg_data;
                    tlbp_pkg::CFG_HISTORY_MODE:   r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Hold the request, its indexes, the looked-up history and the result word
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd     <= i_s_tuser;
            r_outcome <= in_outcome;
            r_cond    <= in_cond;
            r_tag     <= in_addr[ADDR_BITS-1:SET_BITS];
            r_set_idx <= in_set_idx;
            r_dir_idx <= in_dir_idx;
        end else if ((r_state == ST_MOD) && set_done && dir_done) begin
            r_set_idx <= set_rem;
            r_dir_idx <= dir_rem;
        end
        if (r_state == ST_HRT) begin
            r_pidx <= hist_sel;
            r_hit  <= hit_sel;
        end
        if (pt_go) begin
            r_pred_out <= tlbp_pkg::pred_of(r_kind, pt_rdata);
            r_hit_out  <= r_hit;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_hit_out, r_pred_out};

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    a_result_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PT && r_m_valid && !i_m_tready) |=> (r_state == ST_PT && r_m_valid))
        else $error("pending result overrun while output stalled");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_PT))
        else $error("result word raised outside the pattern stage");
`endif

endmodule

// ===== tb/two_level_adaptive_branch_predictor_tb.sv =====
module two_level_adaptive_branch_predictor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbp_pkg::*;

    localparam int HIST_BITS   = 12;
    localparam int HRT_ENTRIES = 1024;
    localparam int WAYS        = 4;
    localparam int ADDR_BITS   = 48;
    localparam int SETS        = HRT_ENTRIES / WAYS;
    localparam int SET_BITS    = $clog2(SETS);
    localparam int PT_ENTRIES  = 1 << HIST_BITS;
    localparam int S_DATA_W    = ((ADDR_BITS + 9) / 8) * 8;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int NUM_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int POOL_SIZE      = 32;
    localparam int NUM_DIR        = 26;

    localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

    // Out-of-range automaton kinds: predict not taken, next state zero
    localparam t_kind KIND_BAD_LO = 3'd5;
    localparam t_kind KIND_BAD_HI = 3'd7;

    // Settings walked by the random phases
    localparam t_kind PHASE_KIND [NUM_PHASES] = '{
        KIND_LAST, KIND_A1, KIND_SAT, KIND_A3, KIND_A4,
        KIND_BAD_HI, KIND_A3, KIND_BAD_LO, KIND_SAT
    };
    localparam logic PHASE_MODE [NUM_PHASES] = '{
        MODE_ASSOC, MODE_DIRECT, MODE_ASSOC, MODE_DIRECT, MODE_ASSOC,
        MODE_DIRECT, MODE_ASSOC, MODE_ASSOC, MODE_DIRECT
    };

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   cmd;
        logic [ADDR_BITS-1:0]   addr;
        logic                   outcome;
        logic                   cond;
        logic                   typed;
        logic                   exp_pred;
        logic                   exp_hit;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_data;
    } step_t;

    typedef struct packed {
        logic pred;
        logic hit;
    } verdict_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  o_m_tvalid;
    logic                  m_tready;
    logic [7:0]            o_m_tdata;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    two_level_adaptive_branch_predictor #(
        .HIST_BITS   (HIST_BITS),
        .HRT_ENTRIES (HRT_ENTRIES),
        .WAYS        (WAYS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow copy of the predictor state and its registers
    t_kind                 shadow_kind;
    logic                  shadow_mode;
    logic [1:0]            pattern_state [PT_ENTRIES];
    logic [HIST_BITS-1:0]  direct_hist   [HRT_ENTRIES];
    logic [ADDR_BITS-1:0]  way_tag       [HRT_ENTRIES];
    logic [HIST_BITS-1:0]  way_hist      [HRT_ENTRIES];
    logic                  way_valid     [HRT_ENTRIES];
    int                    way_age       [HRT_ENTRIES];

    verdict_t              pending_predictions [$];
    verdict_t              head_v;
    step_t                 dir_steps [NUM_DIR];
    logic [ADDR_BITS-1:0]  addr_pool [POOL_SIZE];

    int send_idle;
    int recv_idle;
    int fail_count;
    int cycle_count;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Next-state tables: two bits per {state, outcome}, lowest entry first
    function automatic logic [1:0] next_state(t_kind kind, logic [1:0] st, logic o);
        logic [15:0] tab;
        logic [2:0]  idx;
        idx = {st, o};
        case (kind)
            KIND_LAST: tab = 16'h4444;
            KIND_A1:   tab = 16'hE4E4;
            KIND_SAT:  tab = 16'hED84;
            KIND_A3:   tab = 16'hE3C4;
            KIND_A4:   tab = 16'hEDC4;
            default:   tab = 16'h0000;
        endcase
        return tab[idx*2 +: 2];
    endfunction

    // Taken bit per state, lowest state first
    function automatic logic taken_of(t_kind kind, logic [1:0] st);
        logic [3:0] tab;
        case (kind)
            KIND_LAST, KIND_A1:         tab = 4'b1110;
            KIND_SAT, KIND_A3, KIND_A4: tab = 4'b1100;
            default:                    tab = 4'b0000;
        endcase
        return tab[st];
    endfunction

    // Clear the shadow state as after reset
    task automatic clear_shadow();
        shadow_kind = KIND_SAT;
        shadow_mode = MODE_ASSOC;
        for (int i = 0; i < PT_ENTRIES; i++) pattern_state[i] = 2'd0;
        for (int i = 0; i < HRT_ENTRIES; i++) begin
            direct_hist[i] = '0;
            way_tag[i]     = '0;
            way_hist[i]    = '0;
            way_valid[i]   = 1'b0;
            way_age[i]     = 0;
        end
    endtask

    // Work out the result of one request word and advance the shadow state
    task automatic compute_prediction(input logic cmd, input logic [ADDR_BITS-1:0] addr,
                                      input logic outcome, input logic cond,
                                      output verdict_t res);
        logic                  upd;
        logic                  found;
        logic                  got;
        logic [HIST_BITS-1:0]  hist;
        logic [ADDR_BITS-1:0]  tag;
        logic [1:0]            st;
        int                    base;
        int                    slot;
        int                    dindex;
        int                    old_age;
        int                    best;
        upd    = (cmd == CMD_UPDATE) && cond;
        found  = 1'b0;
        hist   = '0;
        slot   = 0;
        base   = 0;
        dindex = 0;
        tag    = addr >> SET_BITS;
        res.hit = 1'b1;
        if (shadow_mode == MODE_ASSOC) begin
            base = int'(addr % SETS) * WAYS;
            for (int w = 0; w < WAYS; w++) begin
                if (!found && way_valid[base+w] && way_tag[base+w] == tag) begin
                    found = 1'b1;
                    slot  = base + w;
                end
            end
            res.hit = found;
            if (found) begin
                hist = way_hist[slot];
                // Refresh LRU order on a predict or a real update
                if (cmd == CMD_PREDICT || upd) begin
                    old_age = way_age[slot];
                    for (int w = 0; w < WAYS; w++) begin
                        if (way_valid[base+w] && way_age[base+w] < old_age)
                            way_age[base+w]++;
                    end
                    way_age[slot] = 0;
                end
            end
        end else begin
            dindex = int'(addr % HRT_ENTRIES);
            hist   = direct_hist[dindex];
        end

        st       = pattern_state[hist];
        res.pred = taken_of(shadow_kind, st);

        if (upd) begin
            pattern_state[hist] = next_state(shadow_kind, st, outcome);
            if (shadow_mode == MODE_ASSOC) begin
                if (!found) begin
                    // Allocate the first free way, else evict the oldest
                    got = 1'b0;
                    for (int w = 0; w < WAYS; w++) begin
                        if (!got && !way_valid[base+w]) begin
                            slot = base + w;
                            got  = 1'b1;
                        end
                    end
                    if (!got) begin
                        best = 0;
                        slot = base;
                        for (int w = 0; w < WAYS; w++) begin
                            if (way_age[base+w] >= best) begin
                                best = way_age[base+w];
                                slot = base + w;
                            end
                        end
                        way_valid[slot] = 1'b0;
                    end
                    for (int w = 0; w < WAYS; w++) begin
                        if (way_valid[base+w] && way_age[base+w] < 255)
                            way_age[base+w]++;
                    end
                    way_valid[slot] = 1'b1;
                    way_age[slot]   = 0;
                    way_tag[slot]   = tag;
                end
                way_hist[slot] = {hist[HIST_BITS-2:0], outcome};
            end else begin
                direct_hist[dindex] = {hist[HIST_BITS-2:0], outcome};
            end
        end
    endtask

    // Send one request word and queue its expected result
    task automatic issue_request(input logic cmd, input logic [ADDR_BITS-1:0] addr,
                                 input logic outcome, input logic cond,
                                 input logic typed, input logic exp_pred,
                                 input logic exp_hit);
        verdict_t calc;
        verdict_t v;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-ADDR_BITS-2){1'b0}}, cond, outcome, addr};
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        compute_prediction(cmd, addr, outcome, cond, calc);
        if (typed) begin
            v.pred = exp_pred;
            v.hit  = exp_hit;
        end else begin
            v = calc;
        end
        pending_predictions.push_back(v);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_predictions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_AUTOMATON_KIND)
            shadow_kind = value;
        else if (idx == CFG_HISTORY_MODE)
            shadow_mode = value[0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic step_t row_item(logic cmd, logic [ADDR_BITS-1:0] addr,
                                       logic outcome, logic cond, logic typed,
                                       logic exp_pred, logic exp_hit);
        step_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.cmd      = cmd;
        r.addr     = addr;
        r.outcome  = outcome;
        r.cond     = cond;
        r.typed    = typed;
        r.exp_pred = exp_pred;
        r.exp_hit  = exp_hit;
        return r;
    endfunction

    function automatic step_t row_cfg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] value);
        step_t r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = value;
        return r;
    endfunction

    // Directed table: typed results only where they follow at a glance
    task automatic load_directed();
        // Cold table: misses read zero history
        dir_steps[0]  = row_item(CMD_PREDICT, 48'h0,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_steps[1]  = row_item(CMD_PREDICT, ADDR_MAX,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        // Allocate on update miss, then hit
        dir_steps[2]  = row_item(CMD_UPDATE,  48'h0,     1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_steps[3]  = row_item(CMD_PREDICT, 48'h0,     1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        // Non-conditional update leaves the table alone
        dir_steps[4]  = row_item(CMD_UPDATE,  48'h100,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_steps[5]  = row_item(CMD_PREDICT, 48'h100,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        // Fill set zero, refresh one way, then evict the oldest
        dir_steps[6]  = row_item(CMD_UPDATE,  48'h100,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_steps[7]  = row_item(CMD_UPDATE,  48'h200,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_steps[8]  = row_item(CMD_UPDATE,  48'h300,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_steps[9]  = row_item(CMD_PREDICT, 48'h100,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_steps[10] = row_item(CMD_UPDATE,  48'h400,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_steps[11] = row_item(CMD_PREDICT, 48'h0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_steps[12] = row_item(CMD_UPDATE,  ADDR_MAX,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_steps[13] = row_item(CMD_UPDATE,  ADDR_MAX,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // Out-of-range kind never predicts taken
        dir_steps[14] = row_cfg(CFG_AUTOMATON_KIND, KIND_BAD_HI);
        dir_steps[15] = row_item(CMD_PREDICT, ADDR_MAX,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        dir_steps[16] = row_item(CMD_UPDATE,  ADDR_MAX,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        // Direct table always hits
        dir_steps[17] = row_cfg(CFG_HISTORY_MODE, {2'b00, MODE_DIRECT});
        dir_steps[18] = row_item(CMD_PREDICT, 48'h0,     1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        dir_steps[19] = row_cfg(CFG_AUTOMATON_KIND, KIND_LAST);
        dir_steps[20] = row_item(CMD_UPDATE,  48'h3FF,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_steps[21] = row_item(CMD_PREDICT, 48'h3FF,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_steps[22] = row_item(CMD_UPDATE,  48'hFFFF_FFFF_FC00, 1'b0, 1'b1,
                                 1'b0, 1'b0, 1'b0);
        dir_steps[23] = row_item(CMD_PREDICT, 48'h400,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // Back to the tagged table: its contents were kept
        dir_steps[24] = row_cfg(CFG_HISTORY_MODE, {2'b00, MODE_ASSOC});
        dir_steps[25] = row_item(CMD_PREDICT, ADDR_MAX,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // Receiver: random backpressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_predictions.size() == 0) begin
                $error("result word with no prediction pending: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                head_v = pending_predictions.pop_front();
                if (o_m_tdata[0] !== head_v.pred) begin
                    $error("prediction: expected %0d, actual %0d", head_v.pred, o_m_tdata[0]);
                    fail_count++;
                end
                if (o_m_tdata[1] !== head_v.hit) begin
                    $error("history_hit: expected %0d, actual %0d", head_v.hit, o_m_tdata[1]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_level_adaptive_branch_predictor_tb: FAIL");
            $finish;
        end
    end

    // Main sequence
    initial begin
        logic [63:0]          rnd64;
        logic [ADDR_BITS-1:0] addr;
        logic                 cmd;
        logic                 cond;
        logic                 outcome;

        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        send_idle   = 28;
        recv_idle   = 80;
        fail_count  = 0;
        cycle_count = 0;
        clear_shadow();
        load_directed();

        // Address pool: a dozen tags crowd one set, a few share a direct index
        for (int i = 0; i < POOL_SIZE; i++) begin
            rnd64 = {$urandom, $urandom};
            addr_pool[i] = rnd64[ADDR_BITS-1:0];
            if (i < 12) addr_pool[i][7:0] = 8'h5A;
            if (i < 6)  addr_pool[i][9:0] = 10'h25A;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part
        for (int i = 0; i < NUM_DIR; i++) begin
            if (dir_steps[i].kind == ROW_CFG)
                write_reg(dir_steps[i].cfg_idx, dir_steps[i].cfg_data);
            else
                issue_request(dir_steps[i].cmd, dir_steps[i].addr, dir_steps[i].outcome,
                              dir_steps[i].cond, dir_steps[i].typed,
                              dir_steps[i].exp_pred, dir_steps[i].exp_hit);
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle = 28;
                recv_idle = 80;
            end else if (p < 6) begin
                send_idle = 80;
                recv_idle = 28;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(CFG_AUTOMATON_KIND, PHASE_KIND[p]);
            write_reg(CFG_HISTORY_MODE, {2'b00, PHASE_MODE[p]});
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 85) begin
                    // Mostly conditional updates on recurring branches
                    addr    = addr_pool[$urandom_range(POOL_SIZE-1)];
                    cmd     = ($urandom_range(99) < 70) ? CMD_UPDATE : CMD_PREDICT;
                    cond    = ($urandom_range(99) < 92);
                    outcome = ($urandom_range(99) < 65);
                end else begin
                    rnd64   = {$urandom, $urandom};
                    addr    = rnd64[ADDR_BITS-1:0];
                    cmd     = $urandom_range(1);
                    cond    = $urandom_range(1);
                    outcome = $urandom_range(1);
                end
                issue_request(cmd, addr, outcome, cond, 1'b0, 1'b0, 1'b0);
            end
        end

        settle();
        if (fail_count == 0)
            $display("two_level_adaptive_branch_predictor_tb: PASS");
        else
            $display("two_level_adaptive_branch_predictor_tb: FAIL");
        $finish;
    end

endmodule
